[rtl/core/wavelet_noise_evaluator_unit_macros.svh]
// assertion macros for the wavelet noise evaluator
// used by the top level only; expects clk and rst in scope
`ifndef WAVELET_NOISE_EVALUATOR_UNIT_MACROS_SVH
`define WAVELET_NOISE_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication
`define WNE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WNE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wne_pkg.sv]
// shared types and constants of the wavelet noise evaluator
// no dependencies
package wne_pkg;

  localparam int TILE_SIZE_DEF = 32;
  localparam int MAX_BANDS_DEF = 4;

  // field widths
  localparam int ADDR_IN_W  = 15;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 32;
  localparam int SCALE_W    = 24;
  localparam int BANDS_W    = 3;
  localparam int BWEIGHT_W  = 16;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_WEIGHTS = 4;
  localparam int BAND_IDX_W = 2;

  // datapath widths
  localparam int P_W     = POS_W + SCALE_W;  // scaled position, Q.32
  localparam int Q_W     = P_W + 5;          // band shift plus half offset
  localparam int MID_W   = Q_W - 32 + 1;     // cell index incl. ceil step
  localparam int WGT_W   = 17;               // per-axis weight, Q0.16 up to 1.0
  localparam int WT_W    = 35;               // tap weight, Q.32
  localparam int ACC_W   = 56;               // tap sum, Q.44
  localparam int RAW_W   = ACC_W - 16;       // raw noise, Q.28
  localparam int BPROD_W = BWEIGHT_W + RAW_W;
  localparam int SUM_W   = BPROD_W + 2;
  localparam int PROD_W  = SUM_W - 12 + GAIN_W + 1;
  localparam int FIN_W   = PROD_W - 24;

  // cell index reduction, bits per cycle
  localparam int MOD_STEP  = 3;
  localparam int MOD_CYC   = (MID_W + MOD_STEP - 1) / MOD_STEP;
  localparam int MOD_PAD_W = MOD_CYC * MOD_STEP;
  localparam int MOD_CNT_W = $clog2(MOD_CYC);

  localparam int TAPS      = 27;
  localparam int TAP_CNT_W = 5;

  localparam int CMD_DEPTH = 2;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_GAIN  = 3'd6;

  typedef struct packed {
    logic                  kind;
    logic [ADDR_IN_W-1:0]  tile_address;
    logic [COEF_W-1:0]     coefficient;
    logic [P_W-1:0]        p_x;
    logic [P_W-1:0]        p_y;
    logic [P_W-1:0]        p_z;
  } cmd_t;

  typedef struct packed {
    logic [BANDS_W-1:0]                      band_count;
    logic [NUM_WEIGHTS-1:0][BWEIGHT_W-1:0]   band_weight;
    logic [GAIN_W-1:0]                       norm_gain;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic finish;
  } back_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_MOD, ST_WRAP, ST_TAPS, ST_BAND, ST_NORM, ST_OUT
  } back_state_t;

  // 2^w mod n by repeated doubling, elaboration only
  function automatic int pow2_mod(int w, int n);
    int r;
    r = 1;
    if (r >= n) r = r - n;
    for (int i = 0; i < w; i++) begin
      r = 2 * r;
      if (r >= n) r = r - n;
    end
    return r;
  endfunction

endpackage

[rtl/core/wavelet_noise_evaluator_unit.sv]
// top level of the wavelet noise evaluator: registers, front end, queue, back end
// depends on wne_pkg, wne_front, wne_cmd_fifo, wne_back and the macros header
//
// Items enter through push/full: kind 0 loads one tile coefficient, kind 1
// evaluates noise at pos_x/pos_y/pos_z. Results leave through empty/pop, one
// noise_value per evaluate and none per load, in the order of the items.
// The front end scales the position into a register stage and hands the request
// to a two-deep queue; the back end pops requests and works them one at a time.
// A load is one write of the tile memory in the back end (none for an address
// beyond the memory). An evaluate runs one pass per band (one pass when no
// bands are set): setup, index reduction, wrap, 27 tile reads, drain of the
// tap pipeline, then the band sum; then it normalizes and presents the result
// (raw mode skips normalization). The 27 reads per pass go through the single
// port of the tile memory and set the rate.
// Configuration is to be written through cfg_write/cfg_index/cfg_data only while idle;
// the block itself does not enforce this.
// Reset restores the register defaults and empties queue and output; the tile
// memory is not cleared and must be loaded before use. While the result is
// not popped the back end holds, the queue fills and full rises.
`include "wavelet_noise_evaluator_unit_macros.svh"

module wavelet_noise_evaluator_unit #(
  parameter int TILE_SIZE = wne_pkg::TILE_SIZE_DEF,
  parameter int MAX_BANDS = wne_pkg::MAX_BANDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [wne_pkg::ADDR_IN_W-1:0] tile_address,
  input  logic [wne_pkg::COEF_W-1:0]    coefficient,
  input  logic [wne_pkg::POS_W-1:0]     pos_x,
  input  logic [wne_pkg::POS_W-1:0]     pos_y,
  input  logic [wne_pkg::POS_W-1:0]     pos_z,
  output logic                          empty,
  input  logic                          pop,
  output logic [wne_pkg::OUT_W-1:0]     noise_value,
  input  logic                          cfg_write,
  input  logic [wne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wne_pkg::CFG_W-1:0]     cfg_data
);
  import wne_pkg::*;

  logic [SCALE_W-1:0] scale;
  cfg_t               cfg;
  logic               front_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t               front_cmd, fifo_cmd;
  back_stat_t         back_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale           <= SCALE_W'(24'h010000);
      cfg.band_count  <= '0;
      cfg.band_weight <= '0;
      cfg.norm_gain   <= GAIN_W'(16'h1000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCALE:      scale              <= cfg_data;
        CFG_BAND_COUNT: cfg.band_count     <= cfg_data[BANDS_W-1:0];
        CFG_WEIGHT_0:   cfg.band_weight[0] <= cfg_data[BWEIGHT_W-1:0];
        CFG_WEIGHT_1:   cfg.band_weight[1] <= cfg_data[BWEIGHT_W-1:0];
        CFG_WEIGHT_2:   cfg.band_weight[2] <= cfg_data[BWEIGHT_W-1:0];
        CFG_WEIGHT_3:   cfg.band_weight[3] <= cfg_data[BWEIGHT_W-1:0];
        CFG_NORM_GAIN:  cfg.norm_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  wne_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .tile_address (tile_address),
    .coefficient  (coefficient),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .scale        (scale),
    .cmd_push     (front_push),
    .cmd          (front_cmd),
    .cmd_full     (fifo_full)
  );

  // request queue
  wne_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_cmd),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .dout  (fifo_cmd),
    .empty (fifo_empty)
  );

  // back end
  wne_back #(
    .TILE_SIZE (TILE_SIZE),
    .MAX_BANDS (MAX_BANDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_empty   (fifo_empty),
    .cmd         (fifo_cmd),
    .cmd_pop     (fifo_pop),
    .pop         (pop),
    .empty       (empty),
    .noise_value (noise_value),
    .stat        (back_stat)
  );

  // checks
  `WNE_ASSERT_IMP(a_pop_idle, fifo_pop, back_stat.idle && !fifo_empty, "request popped while busy or queue empty")
  `WNE_ASSERT_IMP(a_finish_slot, back_stat.finish, empty || pop, "result written over an unread result")
  `WNE_ASSERT_NEXT(a_finish_shows, back_stat.finish, !empty, "finished result not presented")
  `WNE_ASSERT_IMP(a_new_result, $fell(empty), $past(back_stat.finish), "result appeared without an evaluation")

endmodule

[rtl/core/wne_front.sv]
// front end: accepts items and scales evaluate positions
// depends on wne_pkg
module wne_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind,
  input  logic [wne_pkg::ADDR_IN_W-1:0] tile_address,
  input  logic [wne_pkg::COEF_W-1:0]    coefficient,
  input  logic [wne_pkg::POS_W-1:0]     pos_x,
  input  logic [wne_pkg::POS_W-1:0]     pos_y,
  input  logic [wne_pkg::POS_W-1:0]     pos_z,
  input  logic [wne_pkg::SCALE_W-1:0]   scale,
  output logic                          cmd_push,
  output wne_pkg::cmd_t                 cmd,
  input  logic                          cmd_full
);
  import wne_pkg::*;

  logic                  stage_valid;
  logic                  take;
  logic signed [P_W:0]   px_n, py_n, pz_n;
  logic signed [SCALE_W:0] scale_s;

  assign full     = stage_valid && cmd_full;
  assign take     = push && !full;
  assign cmd_push = stage_valid;

  // position times scale, Q.32
  assign scale_s = $signed({1'b0, scale});
  assign px_n    = $signed(pos_x) * scale_s;
  assign py_n    = $signed(pos_y) * scale_s;
  assign pz_n    = $signed(pos_z) * scale_s;

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (!cmd_full) begin
      stage_valid <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      cmd.kind         <= kind;
      cmd.tile_address <= tile_address;
      cmd.coefficient  <= coefficient;
      cmd.p_x          <= px_n[P_W-1:0];
      cmd.p_y          <= py_n[P_W-1:0];
      cmd.p_z          <= pz_n[P_W-1:0];
    end
  end

endmodule

[rtl/core/wne_cmd_fifo.sv]
// short request queue between front end and back end
// depends on wne_pkg
module wne_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wne_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output wne_pkg::cmd_t dout,
  output logic          empty
);
  import wne_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             slots [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = count == CNT_W'(CMD_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

endmodule

[rtl/core/wne_back.sv]
// back end: tile memory, band sequencer, interpolation and output register
// depends on wne_pkg
module wne_back #(
  parameter int TILE_SIZE = wne_pkg::TILE_SIZE_DEF,
  parameter int MAX_BANDS = wne_pkg::MAX_BANDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wne_pkg::cfg_t             cfg,
  input  logic                      cmd_empty,
  input  wne_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [wne_pkg::OUT_W-1:0] noise_value,
  output wne_pkg::back_stat_t       stat
);
  import wne_pkg::*;

  localparam int TILE_N  = TILE_SIZE + (TILE_SIZE % 2);
  localparam int ENTRIES = TILE_N * TILE_N * TILE_N;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CW      = $clog2(TILE_N);
  localparam logic [CW:0] N_EXT = (CW + 1)'(TILE_N);
  localparam logic [CW:0] WRAP_C = (CW + 1)'(pow2_mod(MID_W, TILE_N));
  localparam logic [Q_W-1:0] HALF = Q_W'(64'h8000_0000);
  localparam logic [WGT_W-1:0] ONE_W = WGT_W'(20'h10000);
  localparam logic [1:0] TAP_LAST = 2'd2;

  back_state_t state, state_next;

  // sequencing
  logic [BAND_IDX_W-1:0] band;
  logic [BANDS_W-1:0]    nbands, nbands_n;
  logic                  raw_mode, last_band;
  logic [MOD_CNT_W-1:0]  mod_cnt;
  logic [TAP_CNT_W-1:0]  tap_cnt;
  logic [1:0]            ti, tj, tk;
  logic                  issue, finish, mem_we, addr_ok;
  logic                  v1, v2, v3;
  logic                  out_valid;
  logic [2:0]            shift;

  // per-axis state
  logic [P_W-1:0]       p_r   [3];
  logic [MID_W-1:0]     mid_n [3];
  logic [MID_W-1:0]     mid_r [3];
  logic [WGT_W-1:0]     w_n   [3][3];
  logic [WGT_W-1:0]     w_r   [3][3];
  logic [MOD_PAD_W-1:0] msh   [3];
  logic [CW-1:0]        rem   [3];
  logic [CW-1:0]        rem_n [3];
  logic [CW-1:0]        coord_n [3][3];
  logic [CW-1:0]        coord   [3][3];

  // memory
  logic signed [COEF_W-1:0] mem [ENTRIES];
  logic [ADDR_W-1:0]        rd_addr, mem_addr;
  logic signed [COEF_W-1:0] mem_rdata;

  // tap pipeline
  logic [WGT_W-1:0]         wx1, wy1, wz1, wz2;
  logic [2*WGT_W-1:0]       wxy2;
  logic [3*WGT_W-1:0]       wt_full;
  logic [WT_W-1:0]          wt3;
  logic signed [COEF_W-1:0] coef2, coef3;
  logic signed [WT_W+COEF_W:0] tap_prod;
  logic signed [ACC_W-1:0]  acc;

  // band sum and normalization
  logic signed [RAW_W-1:0]   raw;
  logic signed [BPROD_W-1:0] band_prod;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-1:0]  norm_prod, prod_r;
  logic [FIN_W-1:0]          fin;
  logic                      sat_hi, sat_lo;
  logic [OUT_W-1:0]          noise_n;

  assign empty       = !out_valid;
  assign stat.idle   = state == ST_IDLE;
  assign stat.finish = finish;

  assign nbands_n  = (cfg.band_count > BANDS_W'(MAX_BANDS)) ? BANDS_W'(MAX_BANDS)
                                                            : cfg.band_count;
  assign last_band = {1'b0, band} == (nbands - 1'b1);
  assign shift     = raw_mode ? 3'd0 : {1'b0, band} + 3'd1;
  assign addr_ok   = {1'b0, cmd.tile_address} < (ADDR_IN_W + 1)'(ENTRIES);

  // sequencer
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.kind == KIND_EVAL) state_next = ST_SETUP;
          else mem_we = addr_ok;
        end
      end
      ST_SETUP: state_next = ST_MOD;
      ST_MOD: begin
        if (mod_cnt == MOD_CNT_W'(MOD_CYC - 1)) state_next = ST_WRAP;
      end
      ST_WRAP: state_next = ST_TAPS;
      ST_TAPS: begin
        issue = tap_cnt != TAP_CNT_W'(TAPS);
        if (!issue && !v1 && !v2 && !v3) state_next = ST_BAND;
      end
      ST_BAND: begin
        if (raw_mode) state_next = ST_OUT;
        else if (last_band) state_next = ST_NORM;
        else state_next = ST_SETUP;
      end
      ST_NORM: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || pop) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // per-axis cell index and spline weights
  always_comb begin
    logic [Q_W-1:0]  q, u;
    logic [31:0]     frac, t32, tt;
    logic [15:0]     t;
    logic [WGT_W-1:0] s;
    logic [2*WGT_W-1:0] ss;
    for (int a = 0; a < 3; a++) begin
      q    = {{(Q_W - P_W){p_r[a][P_W-1]}}, p_r[a]} << shift;
      u    = q - HALF;
      frac = u[31:0];
      mid_n[a] = {u[Q_W-1], u[Q_W-1:32]} + MID_W'(frac != 32'd0);
      t32  = 32'd0 - frac;
      t    = t32[31:16];
      s    = ONE_W - {1'b0, t};
      tt   = t * t;
      ss   = s * s;
      w_n[a][0] = {2'b00, tt[31:17]};
      w_n[a][2] = ss[2*WGT_W-1:17];
      w_n[a][1] = ONE_W - w_n[a][0] - w_n[a][2];
    end
  end

  // index reduction modulo TILE_N (the tile size rounded up to even), msb first
  always_comb begin
    logic [CW-1:0] r;
    logic [CW:0]   r2;
    for (int a = 0; a < 3; a++) begin
      r = rem[a];
      for (int k = 0; k < MOD_STEP; k++) begin
        r2 = {r, msh[a][MOD_PAD_W-1-k]};
        if (r2 >= N_EXT) r2 = r2 - N_EXT;
        r = r2[CW-1:0];
      end
      rem_n[a] = r;
    end
  end

  // negative index correction and neighbor cells
  always_comb begin
    logic [CW:0] base;
    for (int a = 0; a < 3; a++) begin
      if (!mid_r[a][MID_W-1]) base = {1'b0, rem[a]};
      else if ({1'b0, rem[a]} >= WRAP_C) base = {1'b0, rem[a]} - WRAP_C;
      else base = {1'b0, rem[a]} + N_EXT - WRAP_C;
      coord_n[a][1] = base[CW-1:0];
      coord_n[a][0] = (base == '0) ? CW'(TILE_N - 1) : base[CW-1:0] - 1'b1;
      coord_n[a][2] = (base == N_EXT - 1'b1) ? '0 : base[CW-1:0] + 1'b1;
    end
  end

  // tap address
  always_comb begin
    rd_addr = (ADDR_W'(coord[2][tk]) * ADDR_W'(TILE_N) + ADDR_W'(coord[1][tj]))
              * ADDR_W'(TILE_N) + ADDR_W'(coord[0][ti]);
  end
  assign mem_addr = mem_we ? cmd.tile_address[ADDR_W-1:0] : rd_addr;

  // tile memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= cmd.coefficient;
    else mem_rdata <= mem[mem_addr];
  end

  // arithmetic between stages
  assign wt_full   = wxy2 * wz2;
  assign tap_prod  = $signed({1'b0, wt3}) * coef3;
  assign raw       = acc[ACC_W-1:16];
  assign band_prod = $signed(cfg.band_weight[band]) * raw;
  assign norm_prod = $signed(sum[SUM_W-1:12]) * $signed({1'b0, cfg.norm_gain});
  assign fin       = prod_r[PROD_W-1:24];
  assign sat_hi    = !fin[FIN_W-1] && (|fin[FIN_W-2:OUT_W-1]);
  assign sat_lo    = fin[FIN_W-1] && !(&fin[FIN_W-2:OUT_W-1]);
  assign noise_n   = sat_hi ? {1'b0, {(OUT_W - 1){1'b1}}} :
                     sat_lo ? {1'b1, {(OUT_W - 1){1'b0}}} : fin[OUT_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // control counters and valids
  always_ff @(posedge clk) begin
    if (rst) begin
      band      <= '0;
      nbands    <= '0;
      raw_mode  <= 1'b0;
      mod_cnt   <= '0;
      tap_cnt   <= '0;
      ti        <= '0;
      tj        <= '0;
      tk        <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && cmd_pop && cmd.kind == KIND_EVAL) begin
        band     <= '0;
        nbands   <= nbands_n;
        raw_mode <= nbands_n == '0;
      end
      if (state == ST_BAND && !raw_mode && !last_band) band <= band + 1'b1;
      if (state == ST_SETUP) begin
        mod_cnt <= '0;
        tap_cnt <= '0;
        ti      <= '0;
        tj      <= '0;
        tk      <= '0;
      end
      if (state == ST_MOD) mod_cnt <= mod_cnt + 1'b1;
      if (issue) begin
        tap_cnt <= tap_cnt + 1'b1;
        ti      <= (ti == TAP_LAST) ? '0 : ti + 1'b1;
        if (ti == TAP_LAST) begin
          tj <= (tj == TAP_LAST) ? '0 : tj + 1'b1;
          if (tj == TAP_LAST) tk <= tk + 1'b1;
        end
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (finish) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_pop && cmd.kind == KIND_EVAL) begin
      p_r[0] <= cmd.p_x;
      p_r[1] <= cmd.p_y;
      p_r[2] <= cmd.p_z;
      sum    <= '0;
    end
    if (state == ST_SETUP) begin
      mid_r <= mid_n;
      w_r   <= w_n;
      for (int a = 0; a < 3; a++) begin
        msh[a] <= MOD_PAD_W'(mid_n[a]);
        rem[a] <= '0;
      end
    end
    if (state == ST_MOD) begin
      rem <= rem_n;
      for (int a = 0; a < 3; a++) msh[a] <= msh[a] << MOD_STEP;
    end
    if (state == ST_WRAP) coord <= coord_n;
    if (state == ST_BAND) begin
      if (raw_mode) prod_r <= {{(PROD_W - RAW_W - 12){raw[RAW_W-1]}}, raw, 12'd0};
      else sum <= sum + {{(SUM_W - BPROD_W){band_prod[BPROD_W-1]}}, band_prod};
    end
    if (state == ST_NORM) prod_r <= norm_prod;
    if (finish) noise_value <= noise_n;
  end

  // tap pipeline: weights, memory data, product, accumulate
  always_ff @(posedge clk) begin
    wx1   <= w_r[0][ti];
    wy1   <= w_r[1][tj];
    wz1   <= w_r[2][tk];
    wxy2  <= wx1 * wy1;
    wz2   <= wz1;
    coef2 <= mem_rdata;
    wt3   <= wt_full[WT_W+15:16];
    coef3 <= coef2;
    if (state == ST_SETUP) acc <= '0;
    else if (v3) acc <= acc + {{(ACC_W - WT_W - COEF_W - 1){tap_prod[WT_W+COEF_W]}}, tap_prod};
  end

endmodule
